[src/slt_pkg.sv]
// slt_pkg: shared types and constants of the step lock slot table
// used by step_lock_slot_table; no dependencies
`default_nettype none

package slt_pkg;

   localparam logic [7:0] EMPTY_VALUE = 8'hFF;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_DATA_W = 7;

   typedef enum logic [3:0] {
      OP_ADD       = 4'd0,
      OP_CLR_STEP  = 4'd1,
      OP_READ      = 4'd2,
      OP_LOCKED    = 4'd3,
      OP_CLR_PAIR  = 4'd4,
      OP_CLR_TRACK = 4'd5,
      OP_FREE      = 4'd6,
      OP_EMPTY     = 4'd7,
      OP_PATTERN   = 4'd8,
      OP_SWEEP     = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      REG_SLOTS  = 2'd0,
      REG_STEPS  = 2'd1,
      REG_PARAMS = 2'd2
   } reg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_PARAM,
      ST_LK_MAP,
      ST_LK_OWN,
      ST_LK_CHK,
      ST_ALLOC,
      ST_FILL,
      ST_WRITE,
      ST_RD_WAIT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SWEEP,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

[src/slt_ram.sv]
// slt_ram: simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`default_nettype none

module slt_ram #(
   parameter int WIDTH = 8,
   parameter int AW    = 6,
   parameter int DEPTH = 64
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[src/step_lock_slot_table.sv]
// step_lock_slot_table: sparse per-step parameter store with slot sequencer
// depends on slt_pkg and slt_ram
`default_nettype none

//  channel   direction  handshake            payload
//  req_      in         req_tvalid/tready    op, track, param, step, value, slot, trigger_mask
//  rsp_      out        rsp_tvalid/tready    accepted, read_value, answer
//  csr_      in         csr_valid/ready      register index, data
//
//  after reset the step memory is swept to 255 and the pair map to slot 0 before the
//  first request is taken; register writes are taken throughout.
//  one request at a time: a lookup runs the map, owner and check states, a slot fill
//  writes each active step, an emptiness scan reads and checks active steps in turn,
//  allocation tries slots in turn; clear track and sweep repeat these per parameter or
//  per slot. the step memory port sets the pace.
//  a finished response waits in the output register while the next request is taken.

module step_lock_slot_table #(
   parameter int SLOT_COUNT  = 64,
   parameter int STEP_COUNT  = 64,
   parameter int TRACK_COUNT = 16,
   parameter int PARAM_COUNT = 24
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // op[3:0] track[7:4] param[12:8] step[18:13] value[26:19] slot[32:27] trigger_mask[96:33]
   input  wire logic [slt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // accepted[0] read_value[8:1] answer[9]
   output logic      [slt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [slt_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int SW        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int PW        = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
   localparam int PAIRS     = TRACK_COUNT * PARAM_COUNT;
   localparam int XW        = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int MAW       = SW + PW;
   localparam int MEM_DEPTH = SLOT_COUNT * (2 ** PW);
   localparam int CLR_DEPTH = (MEM_DEPTH > PAIRS) ? MEM_DEPTH : PAIRS;
   localparam int CW        = $clog2(CLR_DEPTH);
   localparam int OW        = 9;

   slt_pkg::state_type state_ff, state_in;

   logic [6:0] slots_ff, slots_in;
   logic [6:0] steps_ff, steps_in;
   logic [4:0] params_ff, params_in;

   slt_pkg::op_type op_ff, op_in;
   logic [3:0]  track_ff, track_in;
   logic [4:0]  param_ff, param_in;
   logic [5:0]  step_ff, step_in;
   logic [7:0]  value_ff, value_in;
   logic [5:0]  slot_ff, slot_in;
   logic [63:0] trig_ff, trig_in;

   logic [SW-1:0]  cur_ff, cur_in;
   logic [6:0]     idx_ff, idx_in;
   logic [5:0]     lkp_ff, lkp_in;
   logic [8:0]     scn_ff, scn_in;
   logic [CW-1:0]  clr_ff, clr_in;
   logic           map_ok_ff, map_ok_in;
   logic           acc_ff, acc_in;
   logic [7:0]     rdv_ff, rdv_in;
   logic           ans_ff, ans_in;

   logic [SLOT_COUNT-1:0] valid_ff, valid_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [slt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [8:0] n_slots;
   logic [6:0] n_steps;
   logic [4:0] n_params;
   logic [4:0] lk_param;
   logic       track_ok, param_ok, pair_ok, step_ok, slot_ok;
   logic [XW-1:0] pair_idx;
   logic       found, rsp_free, req_fire, csr_fire;
   logic       step_more, scan_bad, scan_end, scan_empty, alloc_hit, clr_last;
   logic [SW-1:0] scn_slot;

   logic           smem_we;
   logic [MAW-1:0] smem_waddr, smem_raddr;
   logic [7:0]     smem_wdata, step_rd;
   logic           alloc_we;
   logic           clearing;
   logic           map_we;
   logic [XW-1:0]  map_waddr;
   logic [SW-1:0]  map_wdata;
   logic [SW-1:0]  map_rd;
   logic [OW-1:0]  own_rd;

   slt_ram #(.WIDTH(8), .AW(MAW), .DEPTH(MEM_DEPTH)) u_step_mem (
      .clock   (clock),
      .wr_en   (smem_we),
      .wr_addr (smem_waddr),
      .wr_data (smem_wdata),
      .rd_addr (smem_raddr),
      .rd_data (step_rd)
   );

   slt_ram #(.WIDTH(SW), .AW(XW), .DEPTH(PAIRS)) u_map_mem (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (pair_idx),
      .rd_data (map_rd)
   );

   slt_ram #(.WIDTH(OW), .AW(SW), .DEPTH(SLOT_COUNT)) u_owner_mem (
      .clock   (clock),
      .wr_en   (alloc_we),
      .wr_addr (scn_slot),
      .wr_data ({track_ff, param_ff}),
      .rd_addr (map_rd),
      .rd_data (own_rd)
   );

   assign req_tready = (state_ff == slt_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // effective limits
   assign n_slots  = (9'(slots_ff) < 9'(SLOT_COUNT)) ? 9'(slots_ff) : 9'(SLOT_COUNT);
   assign n_steps  = (steps_ff < 7'(STEP_COUNT)) ? steps_ff : 7'(STEP_COUNT);
   assign n_params = (7'(params_ff) < 7'(PARAM_COUNT)) ? params_ff : 5'(PARAM_COUNT);

   assign lk_param = lkp_ff[4:0];
   assign track_ok = 32'(track_ff) < TRACK_COUNT;
   assign param_ok = 32'(lk_param) < PARAM_COUNT;
   assign pair_ok  = track_ok && param_ok;
   assign step_ok  = 32'(step_ff) < STEP_COUNT;
   assign slot_ok  = 32'(slot_ff) < SLOT_COUNT;
   assign pair_idx = XW'(32'(track_ff) * 32'(PARAM_COUNT) + 32'(lk_param));
   assign scn_slot = scn_ff[SW-1:0];

   // a stale map entry only counts when its slot is live and owned by this pair
   assign found = map_ok_ff && (own_rd == {track_ff, lk_param});

   assign step_more = idx_ff < n_steps;
   assign scan_bad  = (op_ff == slt_pkg::OP_PATTERN)
                    ? ((slot_ok && step_rd != slt_pkg::EMPTY_VALUE) || !trig_ff[idx_ff[5:0]])
                    : (step_rd != slt_pkg::EMPTY_VALUE);
   assign scan_empty = (state_ff == slt_pkg::ST_SCAN_RD) && !step_more;
   assign scan_end   = scan_empty || ((state_ff == slt_pkg::ST_SCAN_CHK) && scan_bad);
   assign alloc_hit  = (state_ff == slt_pkg::ST_ALLOC) && (scn_ff < n_slots)
                     && !valid_ff[scn_slot];
   assign alloc_we   = alloc_hit;
   assign clr_last   = clr_ff == CW'(CLR_DEPTH - 1);

   // pair map is set to slot 0 during the clear pass; slot 0 is free then
   assign clearing  = (state_ff == slt_pkg::ST_CLEAR);
   assign map_we    = alloc_we || (clearing && (32'(clr_ff) < PAIRS));
   assign map_waddr = clearing ? clr_ff[XW-1:0] : pair_idx;
   assign map_wdata = clearing ? '0 : scn_slot;

   // step memory ports
   always_comb begin
      smem_we    = 1'b0;
      smem_waddr = {cur_ff, step_ff[PW-1:0]};
      smem_wdata = slt_pkg::EMPTY_VALUE;
      unique case (state_ff)
         slt_pkg::ST_CLEAR: begin
            smem_we    = 32'(clr_ff) < MEM_DEPTH;
            smem_waddr = clr_ff[MAW-1:0];
         end
         slt_pkg::ST_FILL: begin
            smem_we    = step_more;
            smem_waddr = {cur_ff, idx_ff[PW-1:0]};
         end
         slt_pkg::ST_WRITE: begin
            smem_we    = 1'b1;
            smem_wdata = value_ff;
         end
         slt_pkg::ST_LK_CHK: begin
            smem_we = (op_ff == slt_pkg::OP_CLR_STEP) && found && step_ok;
         end
         default: begin
            smem_we = 1'b0;
         end
      endcase
   end

   assign smem_raddr = (state_ff == slt_pkg::ST_SCAN_RD) ? {cur_ff, idx_ff[PW-1:0]}
                                                         : {cur_ff, step_ff[PW-1:0]};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slt_pkg::ST_CLEAR: begin
            if (clr_last) state_in = slt_pkg::ST_IDLE;
         end
         slt_pkg::ST_IDLE: begin
            if (req_fire) state_in = slt_pkg::ST_START;
         end
         slt_pkg::ST_START: begin
            unique case (op_ff)
               slt_pkg::OP_ADD, slt_pkg::OP_CLR_STEP, slt_pkg::OP_READ,
               slt_pkg::OP_LOCKED, slt_pkg::OP_CLR_PAIR:
                  state_in = pair_ok ? slt_pkg::ST_LK_MAP : slt_pkg::ST_RESP;
               slt_pkg::OP_CLR_TRACK: state_in = slt_pkg::ST_PARAM;
               slt_pkg::OP_FREE:      state_in = slot_ok ? slt_pkg::ST_FILL : slt_pkg::ST_RESP;
               slt_pkg::OP_EMPTY:     state_in = slot_ok ? slt_pkg::ST_SCAN_RD
                                                         : slt_pkg::ST_RESP;
               slt_pkg::OP_PATTERN:   state_in = slt_pkg::ST_SCAN_RD;
               slt_pkg::OP_SWEEP:     state_in = slt_pkg::ST_SWEEP;
               default:               state_in = slt_pkg::ST_RESP;
            endcase
         end
         slt_pkg::ST_PARAM: begin
            state_in = (lkp_ff >= {1'b0, n_params} || !track_ok) ? slt_pkg::ST_RESP
                                                                  : slt_pkg::ST_LK_MAP;
         end
         slt_pkg::ST_LK_MAP: state_in = slt_pkg::ST_LK_OWN;
         slt_pkg::ST_LK_OWN: state_in = slt_pkg::ST_LK_CHK;
         slt_pkg::ST_LK_CHK: begin
            unique case (op_ff)
               slt_pkg::OP_ADD:
                  state_in = !found ? slt_pkg::ST_ALLOC
                           : (step_ok ? slt_pkg::ST_WRITE : slt_pkg::ST_RESP);
               slt_pkg::OP_CLR_STEP:
                  state_in = found ? slt_pkg::ST_SCAN_RD : slt_pkg::ST_RESP;
               slt_pkg::OP_READ:
                  state_in = (found && step_ok) ? slt_pkg::ST_RD_WAIT : slt_pkg::ST_RESP;
               slt_pkg::OP_CLR_PAIR:
                  state_in = found ? slt_pkg::ST_FILL : slt_pkg::ST_RESP;
               slt_pkg::OP_CLR_TRACK:
                  state_in = found ? slt_pkg::ST_FILL : slt_pkg::ST_PARAM;
               default:
                  state_in = slt_pkg::ST_RESP;
            endcase
         end
         slt_pkg::ST_ALLOC: begin
            if (scn_ff >= n_slots) state_in = slt_pkg::ST_RESP;
            else if (!valid_ff[scn_slot]) state_in = slt_pkg::ST_FILL;
         end
         slt_pkg::ST_FILL: begin
            if (!step_more) begin
               if (op_ff == slt_pkg::OP_ADD)
                  state_in = step_ok ? slt_pkg::ST_WRITE : slt_pkg::ST_RESP;
               else if (op_ff == slt_pkg::OP_CLR_TRACK)
                  state_in = slt_pkg::ST_PARAM;
               else
                  state_in = slt_pkg::ST_RESP;
            end
         end
         slt_pkg::ST_WRITE:   state_in = slt_pkg::ST_RESP;
         slt_pkg::ST_RD_WAIT: state_in = slt_pkg::ST_RESP;
         slt_pkg::ST_SCAN_RD, slt_pkg::ST_SCAN_CHK: begin
            if (scan_end) begin
               if (op_ff == slt_pkg::OP_CLR_STEP)
                  state_in = scan_empty ? slt_pkg::ST_FILL : slt_pkg::ST_RESP;
               else if (op_ff == slt_pkg::OP_SWEEP)
                  state_in = slt_pkg::ST_SWEEP;
               else
                  state_in = slt_pkg::ST_RESP;
            end else begin
               state_in = (state_ff == slt_pkg::ST_SCAN_RD) ? slt_pkg::ST_SCAN_CHK
                                                            : slt_pkg::ST_SCAN_RD;
            end
         end
         slt_pkg::ST_SWEEP: begin
            if (scn_ff >= n_slots) state_in = slt_pkg::ST_RESP;
            else if (valid_ff[scn_slot]) state_in = slt_pkg::ST_SCAN_RD;
         end
         slt_pkg::ST_RESP: begin
            if (rsp_free) state_in = slt_pkg::ST_IDLE;
         end
         default: state_in = slt_pkg::ST_IDLE;
      endcase
   end

   // register updates
   always_comb begin
      slots_in  = slots_ff;
      steps_in  = steps_ff;
      params_in = params_ff;
      op_in     = op_ff;
      track_in  = track_ff;
      param_in  = param_ff;
      step_in   = step_ff;
      value_in  = value_ff;
      slot_in   = slot_ff;
      trig_in   = trig_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      lkp_in    = lkp_ff;
      scn_in    = scn_ff;
      clr_in    = clr_ff;
      map_ok_in = map_ok_ff;
      acc_in    = acc_ff;
      rdv_in    = rdv_ff;
      ans_in    = ans_ff;
      valid_in  = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_fire) begin
         unique case (csr_index)
            slt_pkg::REG_SLOTS:  slots_in  = csr_data;
            slt_pkg::REG_STEPS:  steps_in  = csr_data;
            slt_pkg::REG_PARAMS: params_in = csr_data[4:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         slt_pkg::ST_CLEAR: begin
            clr_in = clr_ff + CW'(1);
         end
         slt_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in    = slt_pkg::op_type'(req_tdata[3:0]);
               track_in = req_tdata[7:4];
               param_in = req_tdata[12:8];
               step_in  = req_tdata[18:13];
               value_in = req_tdata[26:19];
               slot_in  = req_tdata[32:27];
               trig_in  = req_tdata[96:33];
               lkp_in   = {1'b0, req_tdata[12:8]};
               acc_in   = 1'b1;
               rdv_in   = slt_pkg::EMPTY_VALUE;
               ans_in   = 1'b0;
               idx_in   = '0;
               scn_in   = '0;
            end
         end
         slt_pkg::ST_START: begin
            cur_in = SW'(slot_ff);
            if (op_ff == slt_pkg::OP_ADD && !pair_ok) acc_in = 1'b0;
            if (op_ff == slt_pkg::OP_EMPTY && !slot_ok) ans_in = 1'b1;
            if (op_ff == slt_pkg::OP_CLR_TRACK) lkp_in = '0;
         end
         slt_pkg::ST_LK_OWN: begin
            cur_in    = map_rd;
            map_ok_in = (32'(map_rd) < SLOT_COUNT) && valid_ff[map_rd];
         end
         slt_pkg::ST_LK_CHK: begin
            idx_in = '0;
            if (op_ff == slt_pkg::OP_LOCKED) ans_in = found;
            if (op_ff == slt_pkg::OP_CLR_TRACK && !found) lkp_in = lkp_ff + 6'd1;
         end
         slt_pkg::ST_ALLOC: begin
            if (scn_ff >= n_slots) begin
               acc_in = 1'b0;
            end else if (!valid_ff[scn_slot]) begin
               valid_in[scn_slot] = 1'b1;
               cur_in = scn_slot;
            end else begin
               scn_in = scn_ff + 9'd1;
            end
         end
         slt_pkg::ST_FILL: begin
            if (step_more) begin
               idx_in = idx_ff + 7'd1;
            end else if (op_ff != slt_pkg::OP_ADD) begin
               valid_in[cur_ff] = 1'b0;
               if (op_ff == slt_pkg::OP_CLR_TRACK) lkp_in = lkp_ff + 6'd1;
            end
         end
         slt_pkg::ST_RD_WAIT: begin
            rdv_in = step_rd;
         end
         slt_pkg::ST_SCAN_RD, slt_pkg::ST_SCAN_CHK: begin
            if (scan_end) begin
               if (op_ff == slt_pkg::OP_EMPTY || op_ff == slt_pkg::OP_PATTERN)
                  ans_in = scan_empty;
               idx_in = '0;
               if (op_ff == slt_pkg::OP_SWEEP) begin
                  if (scan_empty) valid_in[cur_ff] = 1'b0;
                  scn_in = scn_ff + 9'd1;
               end
            end else if (state_ff == slt_pkg::ST_SCAN_CHK) begin
               idx_in = idx_ff + 7'd1;
            end
         end
         slt_pkg::ST_SWEEP: begin
            if (scn_ff < n_slots) begin
               if (valid_ff[scn_slot]) begin
                  cur_in = scn_slot;
                  idx_in = '0;
               end else begin
                  scn_in = scn_ff + 9'd1;
               end
            end
         end
         slt_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, ans_ff, rdv_ff, acc_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slt_pkg::ST_CLEAR;
         slots_ff     <= 7'd64;
         steps_ff     <= 7'd64;
         params_ff    <= 5'd24;
         valid_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slots_ff     <= slots_in;
         steps_ff     <= steps_in;
         params_ff    <= params_in;
         valid_ff     <= valid_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      track_ff    <= track_in;
      param_ff    <= param_in;
      step_ff     <= step_in;
      value_ff    <= value_in;
      slot_ff     <= slot_in;
      trig_ff     <= trig_in;
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      lkp_ff      <= lkp_in;
      scn_ff      <= scn_in;
      map_ok_ff   <= map_ok_in;
      acc_ff      <= acc_in;
      rdv_ff      <= rdv_in;
      ans_ff      <= ans_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
